// ===== rtl/tmq_pkg.sv =====
// ----------------------------------------------------------------------------
// tmq_pkg
// shared constants and codes for the timed message queue
// ----------------------------------------------------------------------------
`default_nettype none
package tmq_pkg;
  localparam int QUEUE_DEPTH  = 16;
  localparam int HANDLER_BITS = 8;
  localparam int TIME_W       = 63;
  localparam int DELAY_W      = 32;
  localparam int WHAT_W       = 32;
  localparam int ARG_W        = 64;
  localparam int MS_W         = 10;
  localparam int PROD_W       = DELAY_W + MS_W;
  localparam logic [MS_W-1:0]   MS_TO_US = MS_W'(1000);
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_POST   = 2'd0,
    KIND_POLL   = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOTHING    = 3'd1,
    ST_FULL       = 3'd2,
    ST_STOPPED    = 3'd3,
    ST_NO_HANDLER = 3'd4
  } status_t;
endpackage
`default_nettype wire

// ===== rtl/tmq_if.sv =====
// ----------------------------------------------------------------------------
// tmq_if
// request and response channels of the timed message queue
// ----------------------------------------------------------------------------
`default_nettype none
interface tmq_req_if #(
  parameter int HANDLER_BITS = tmq_pkg::HANDLER_BITS
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   kind;
  logic [tmq_pkg::TIME_W-1:0]   now_us;
  logic [tmq_pkg::DELAY_W-1:0]  delay_ms;
  logic [HANDLER_BITS-1:0]      handler_id;
  logic signed [tmq_pkg::WHAT_W-1:0] what;
  logic [tmq_pkg::ARG_W-1:0]    argument;
  modport source (output valid, kind, now_us, delay_ms, handler_id, what, argument,
                  input ready);
  modport sink (input valid, kind, now_us, delay_ms, handler_id, what, argument,
                output ready);
endinterface

interface tmq_rsp_if #(
  parameter int HANDLER_BITS = tmq_pkg::HANDLER_BITS,
  parameter int CNT_W        = 5
);
  logic                         valid;
  logic                         ready;
  logic [2:0]                   status;
  logic [HANDLER_BITS-1:0]      out_handler;
  logic signed [tmq_pkg::WHAT_W-1:0] out_what;
  logic [tmq_pkg::ARG_W-1:0]    out_argument;
  logic [CNT_W-1:0]             removed_count;
  logic [CNT_W-1:0]             pending_count;
  modport source (output valid, status, out_handler, out_what, out_argument,
                  removed_count, pending_count, input ready);
  modport sink (input valid, status, out_handler, out_what, out_argument,
                removed_count, pending_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/tmq_ram.sv =====
// ----------------------------------------------------------------------------
// tmq_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none
module tmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/timed_message_queue.sv =====
// poll reads the head entry, remove walks every queued entry, post walks each entry
// with a later due time; words answered at once (rejected, stopped, empty queue,
// unused kind) go straight to the response register
// throughput: one word at a time; the entry ram walk sets the rate
// reset: synchronous, clears count, head pointer, stopped and response valid
// ----------------------------------------------------------------------------
// timed_message_queue
// due-time sorted message queue held in a circular entry ram
// ----------------------------------------------------------------------------
`default_nettype none
module timed_message_queue #(
  parameter int QUEUE_DEPTH  = tmq_pkg::QUEUE_DEPTH,
  parameter int HANDLER_BITS = tmq_pkg::HANDLER_BITS,
  parameter int CNT_W        = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata,
  tmq_req_if.sink   req,
  tmq_rsp_if.source rsp
);
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int TW    = tmq_pkg::TIME_W;
  localparam int ENT_W = TW + HANDLER_BITS + tmq_pkg::WHAT_W + tmq_pkg::ARG_W;

  typedef struct packed {
    logic [TW-1:0]               due;
    logic [HANDLER_BITS-1:0]     handler;
    logic [tmq_pkg::WHAT_W-1:0]  what;
    logic [tmq_pkg::ARG_W-1:0]   arg;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DUE, S_SCAN, S_CMP, S_POLL, S_RRD, S_RCHK, S_RESP
  } state_t;

  state_t                      state;
  logic                        stopped;
  logic [CNT_W-1:0]            count;
  logic [IDX_W-1:0]            head;
  logic [CNT_W-1:0]            pos;
  logic [CNT_W-1:0]            wpos;
  logic [TW-1:0]               now;
  logic [tmq_pkg::PROD_W-1:0]  prod;
  entry_t                      item;
  logic [2:0]                  status;
  entry_t                      res;
  logic [CNT_W-1:0]            removed;
  logic [TW:0]                 sum;

  logic                        we;
  logic [IDX_W-1:0]            waddr;
  logic [IDX_W-1:0]            raddr;
  entry_t                      wdata;
  logic [ENT_W-1:0]            rdata;
  entry_t                      rd;

  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] h,
                                            input logic [CNT_W-1:0] l);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(h) + (CNT_W+1)'(l);
    if (s >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      s = s - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  assign rd  = entry_t'(rdata);
  assign sum = (TW+1)'(now) + (TW+1)'(prod);

  always_comb begin
    we    = 1'b0;
    waddr = phys(head, pos);
    wdata = item;
    raddr = head;
    case (state)
      S_SCAN: begin
        raddr = phys(head, pos - CNT_W'(1));
        we    = (pos == '0);
      end
      S_CMP: begin
        we = 1'b1;
        if (rd.due > item.due) begin
          wdata = rd;
        end
      end
      S_RRD: begin
        raddr = phys(head, pos);
      end
      S_RCHK: begin
        waddr = phys(head, wpos);
        wdata = rd;
        we    = !(rd.handler == item.handler && rd.what == item.what);
      end
      default: begin
      end
    endcase
  end

  tmq_ram #(.WIDTH(ENT_W), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      stopped   <= 1'b0;
      count     <= '0;
      head      <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        stopped <= cfg_wdata;
      end
      if (rsp.valid && rsp.ready && state != S_RESP) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            now          <= req.now_us;
            item.handler <= req.handler_id;
            item.what    <= req.what;
            item.arg     <= req.argument;
            res          <= '0;
            removed      <= '0;
            status       <= tmq_pkg::ST_OK;
            pos          <= '0;
            wpos         <= '0;
            prod         <= tmq_pkg::PROD_W'(req.delay_ms) *
                            tmq_pkg::PROD_W'(tmq_pkg::MS_TO_US);
            state        <= S_RESP;
            case (req.kind)
              tmq_pkg::KIND_POST: begin
                if (req.handler_id == '0) begin
                  status <= tmq_pkg::ST_NO_HANDLER;
                end else if (stopped) begin
                  status <= tmq_pkg::ST_STOPPED;
                end else if (count == CNT_W'(QUEUE_DEPTH)) begin
                  status <= tmq_pkg::ST_FULL;
                end else begin
                  state <= S_DUE;
                end
              end
              tmq_pkg::KIND_POLL: begin
                if (stopped) begin
                  status <= tmq_pkg::ST_STOPPED;
                end else if (count == '0) begin
                  status <= tmq_pkg::ST_NOTHING;
                end else begin
                  state <= S_POLL;
                end
              end
              tmq_pkg::KIND_REMOVE: begin
                if (stopped) begin
                  status <= tmq_pkg::ST_STOPPED;
                end else begin
                  state <= S_RRD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_DUE: begin
          item.due <= sum[TW] ? tmq_pkg::TIME_MAX : sum[TW-1:0];
          pos      <= count;
          state    <= S_SCAN;
        end
        S_SCAN: begin
          if (pos == '0) begin
            count <= count + CNT_W'(1);
            state <= S_RESP;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (rd.due > item.due) begin
            pos   <= pos - CNT_W'(1);
            state <= S_SCAN;
          end else begin
            count <= count + CNT_W'(1);
            state <= S_RESP;
          end
        end
        S_POLL: begin
          if (now >= rd.due) begin
            res   <= rd;
            head  <= phys(head, CNT_W'(1));
            count <= count - CNT_W'(1);
          end else begin
            status <= tmq_pkg::ST_NOTHING;
          end
          state <= S_RESP;
        end
        S_RRD: begin
          if (pos == count) begin
            removed <= count - wpos;
            count   <= wpos;
            state   <= S_RESP;
          end else begin
            state <= S_RCHK;
          end
        end
        S_RCHK: begin
          if (we) begin
            wpos <= wpos + CNT_W'(1);
          end
          pos   <= pos + CNT_W'(1);
          state <= S_RRD;
        end
        S_RESP: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid         <= 1'b1;
            rsp.status        <= status;
            rsp.out_handler   <= res.handler;
            rsp.out_what      <= res.what;
            rsp.out_argument  <= res.arg;
            rsp.removed_count <= removed;
            rsp.pending_count <= count;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/tmq_checker.sv =====
// ----------------------------------------------------------------------------
// tmq_checker
// port-level checks of the timed message queue
// ----------------------------------------------------------------------------
`default_nettype none
module tmq_checker #(
  parameter int QUEUE_DEPTH  = tmq_pkg::QUEUE_DEPTH,
  parameter int HANDLER_BITS = tmq_pkg::HANDLER_BITS,
  parameter int CNT_W        = $clog2(QUEUE_DEPTH + 1)
) (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    req_valid,
  input wire logic                    req_ready,
  input wire logic                    rsp_valid,
  input wire logic                    rsp_ready,
  input wire logic [2:0]              status,
  input wire logic [HANDLER_BITS-1:0] out_handler,
  input wire logic [CNT_W-1:0]        removed_count,
  input wire logic [CNT_W-1:0]        pending_count
);
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response word dropped while stalled");

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending_count <= CNT_W'(QUEUE_DEPTH))
    else $error("pending count beyond depth");

  a_no_delivery: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != tmq_pkg::ST_OK |-> out_handler == '0 && removed_count == '0)
    else $error("payload on rejected word");

  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second word taken while busy");
endmodule

bind timed_message_queue tmq_checker #(
  .QUEUE_DEPTH  (QUEUE_DEPTH),
  .HANDLER_BITS (HANDLER_BITS),
  .CNT_W        (CNT_W)
) u_tmq_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .status        (rsp.status),
  .out_handler   (rsp.out_handler),
  .removed_count (rsp.removed_count),
  .pending_count (rsp.pending_count)
);
`default_nettype wire
